// File: src/u2da_pkg.sv
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared types and constants for the unsigned binary to decimal ASCII block.
// ----------------------------------------------------------------------------
package u2da_pkg;

    // Width of the binary request value that takes part in the conversion
    // (at most the 32-bit port width).
    localparam int VALUE_WIDTH = 32;

    // Decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1.
    localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;

    // Counter widths.
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W      = $clog2(NUM_DIGITS + 1);

    // ASCII code of '0', in the 6-bit character field.
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // One BCD digit.
    typedef logic [3:0] t_digit;

    // Control of every cell in the digit chain.
    typedef struct packed {
        logic clear;    // zero the digit
        logic conv;     // add-3 correction, then shift in the neighbor's carry
        logic move;     // take the lower neighbor's digit
    } t_cell_ctrl;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

endpackage

// File: src/u2da_cell.sv
// ----------------------------------------------------------------------------
// u2da_cell
// One BCD digit of the conversion chain: shift-and-add-3 step, or digit move.
// ----------------------------------------------------------------------------
module u2da_cell (
    input  logic                  i_clk,
    input  u2da_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_carry,
    input  u2da_pkg::t_digit      i_digit,
    output logic                  o_carry,
    output u2da_pkg::t_digit      o_digit
);

    u2da_pkg::t_digit r_digit;
    u2da_pkg::t_digit n_digit;
    u2da_pkg::t_digit w_adj;

    // Correct digits of five and above so the shift carries into the next cell
    always_comb begin
        w_adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    end

    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    // Select the next digit
    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.conv) begin
            n_digit = {w_adj[2:0], i_carry};
        end else if (i_ctrl.move) begin
            n_digit = i_digit;
        end
    end

    // Hold the digit
    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// File: src/u2da_chain.sv
// ----------------------------------------------------------------------------
// u2da_chain
// Row of BCD cells, least significant digit at index zero.
// ----------------------------------------------------------------------------
module u2da_chain (
    input  logic                  i_clk,
    input  u2da_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_bin_msb,
    output u2da_pkg::t_digit      o_top
);

    logic              w_carry [u2da_pkg::NUM_DIGITS+1];
    u2da_pkg::t_digit  w_digit [u2da_pkg::NUM_DIGITS+1];

    // Feed the bottom cell with the binary bit and an empty digit
    assign w_carry[0] = i_bin_msb;
    assign w_digit[0] = '0;

    // Build the row; each cell hands its carry and digit upward
    for (genvar g = 0; g < u2da_pkg::NUM_DIGITS; g++) begin : g_cell
        u2da_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_carry (w_carry[g]),
            .i_digit (w_digit[g]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g+1])
        );
    end

    assign o_top = w_digit[u2da_pkg::NUM_DIGITS];

endmodule

// File: src/unsigned_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii
// Converts one unsigned binary value per request into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Each request is loaded, then runs shift-and-add-3 on all 32 bits through a
// row of ten BCD digit cells (one bit of the value per cycle), then the digits
// shift out of the top cell one per cycle while the output register is free:
// leading zeros are dropped without output, each remaining digit is
// presented on the output register, most significant first, with o_last_digit
// on the final one. The next request is taken once the last digit sits in the
// output register.
module unsigned_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_digit_char,
    output logic        o_last_digit
);

    u2da_pkg::t_state                    r_state;
    u2da_pkg::t_state                    n_state;
    logic [u2da_pkg::VALUE_WIDTH-1:0]    r_bin;
    logic [u2da_pkg::VALUE_WIDTH-1:0]    n_bin;
    logic [u2da_pkg::CNT_W-1:0]          r_cnt;
    logic [u2da_pkg::CNT_W-1:0]          n_cnt;
    logic [u2da_pkg::LEFT_W-1:0]         r_left;
    logic [u2da_pkg::LEFT_W-1:0]         n_left;
    logic                                r_started;
    logic                                n_started;
    logic                                r_out_valid;
    logic                                n_out_valid;
    logic [5:0]                          r_out_char;
    logic [5:0]                          n_out_char;
    logic                                r_out_last;
    logic                                n_out_last;
    u2da_pkg::t_cell_ctrl                w_ctrl;
    u2da_pkg::t_digit                    w_top;
    logic                                w_out_free;
    logic                                w_emit;

    // Digit chain
    u2da_chain u_chain (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_bin_msb (r_bin[u2da_pkg::VALUE_WIDTH-1]),
        .o_top     (w_top)
    );

    assign w_out_free = !r_out_valid || i_ready;

    // Sequence load, conversion and digit output
    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_started   = r_started;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_ready;
        w_ctrl      = '0;
        w_emit      = 1'b0;
        o_ready     = 1'b0;
        unique case (r_state)
            u2da_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_ctrl.clear = 1'b1;
                    n_bin        = i_value[u2da_pkg::VALUE_WIDTH-1:0];
                    n_cnt        = u2da_pkg::CNT_W'(u2da_pkg::VALUE_WIDTH);
                    n_left       = u2da_pkg::LEFT_W'(u2da_pkg::NUM_DIGITS);
                    n_started    = 1'b0;
                    n_state      = u2da_pkg::ST_CONV;
                end
            end
            u2da_pkg::ST_CONV: begin
                w_ctrl.conv = 1'b1;
                n_bin       = r_bin << 1;
                n_cnt       = r_cnt - 1'b1;
                if (r_cnt == u2da_pkg::CNT_W'(1)) begin
                    n_state = u2da_pkg::ST_EMIT;
                end
            end
            u2da_pkg::ST_EMIT: begin
                if (!r_started && (w_top == '0) && (r_left > u2da_pkg::LEFT_W'(1))) begin
                    // drop a leading zero
                    w_ctrl.move = 1'b1;
                    n_left      = r_left - 1'b1;
                end else if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_ctrl.move = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_char  = u2da_pkg::ASCII_ZERO + {2'b00, w_top};
                    n_out_last  = (r_left == u2da_pkg::LEFT_W'(1));
                    n_left      = r_left - 1'b1;
                    n_started   = 1'b1;
                    if (r_left == u2da_pkg::LEFT_W'(1)) begin
                        n_state = u2da_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = u2da_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= u2da_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_started   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_started   <= n_started;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

    // A taken request always starts a conversion
    a_load_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == u2da_pkg::ST_CONV))
        else $error("request taken without starting conversion");

    // A presented digit is always a decimal digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (w_top <= 4'd9))
        else $error("top cell holds a non-decimal digit");

    // Output never runs out of digits before the last one is flagged
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u2da_pkg::ST_EMIT) |-> (r_left != '0))
        else $error("digit count exhausted while emitting");

    // Conversion runs the full bit count
    a_conv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u2da_pkg::ST_CONV) |-> (r_cnt != '0))
        else $error("conversion counter wrapped");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Values go in one request at a time. For each accepted request the bench
// computes the decimal digits, most significant first, and queues them. A
// monitor compares every digit that leaves the block with the oldest queued
// one, character and last flag separately. The stimulus covers edge values,
// random values of every length, idle bursts on both sides, a fully drained
// pause and a final stretch with no idling at all.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } t_digit_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_digit_char;
    logic        o_last_digit;

    t_digit_exp  pending_digits[$];
    logic        idle_bursts;
    int          error_count;
    int          values_sent;
    int          digits_seen;
    int          quiet_cycles;

    unsigned_to_decimal_ascii uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Queue the decimal digits of one value, most significant first
    function automatic void predict_digits(input logic [31:0] value);
        longint unsigned rem;
        int              low_first[20];
        int              count;
        t_digit_exp      d;
        rem = longint'(value) & ((64'd1 << u2da_pkg::VALUE_WIDTH) - 64'd1);
        count = 0;
        do begin
            low_first[count] = int'(rem % 10);
            rem = rem / 10;
            count++;
        end while (rem != 0 && count < 20);
        for (int k = count - 1; k >= 0; k--) begin
            d.ch   = u2da_pkg::ASCII_ZERO + 6'(low_first[k]);
            d.last = (k == 0);
            pending_digits.push_back(d);
        end
    endfunction

    // Random value shifted right by a random amount, so its decimal length spans 1 to 10 digits
    function automatic logic [31:0] random_value();
        return $urandom() >> $urandom_range(0, 31);
    endfunction

    // Present one request and hold it until accepted
    task automatic send_value(input logic [31:0] value);
        if (idle_bursts && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        predict_digits(value);
        values_sent++;
    endtask

    task automatic wait_drained();
        while (pending_digits.size() != 0) @(posedge i_clk);
    endtask

    // Edge values: zero, all ones, digit-count boundaries, every digit
    task automatic test_edge_values();
        logic [31:0] edges[20];
        edges = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
                  32'd999, 32'd1000, 32'd99999, 32'd100000, 32'd999999999,
                  32'd1000000000, 32'd1234567890, 32'd987654321,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'd4000000000};
        idle_bursts = 1'b1;
        foreach (edges[i]) send_value(edges[i]);
    endtask

    // Random values with idle bursts on both sides
    task automatic test_random_bursty(input int n);
        idle_bursts = 1'b1;
        repeat (n) send_value(random_value());
    endtask

    // Hold off the sender until every queued digit has come out
    task automatic test_drained_pause(input int n);
        idle_bursts = 1'b1;
        repeat (n) begin
            send_value(random_value());
            i_valid <= 1'b0;
            wait_drained();
        end
    endtask

    // Full-rate stretch with no idling
    task automatic test_back_to_back(input int n);
        idle_bursts = 1'b0;
        repeat (n) send_value($urandom_range(0, 1) ? $urandom() : random_value());
    endtask

    // Receiver: stall in random bursts while idle bursts are enabled
    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (idle_bursts && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Compare each digit leaving the block with the oldest queued one
    always @(posedge i_clk) begin
        t_digit_exp want;
        if (i_rst_n && o_valid && i_ready) begin
            digits_seen++;
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected digit: expected none, got char %0d last %0b",
                         $time, o_digit_char, o_last_digit);
                error_count++;
            end else begin
                want = pending_digits.pop_front();
                if (o_digit_char !== want.ch) begin
                    $display("%0t: digit char mismatch: expected %0d, got %0d",
                             $time, want.ch, o_digit_char);
                    error_count++;
                end
                if (o_last_digit !== want.last) begin
                    $display("%0t: last flag mismatch: expected %0b, got %0b",
                             $time, want.last, o_last_digit);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset, run the tests in turn, then drain and report
    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_value      <= '0;
        idle_bursts  = 1'b1;
        values_sent  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values();
        test_random_bursty(140);
        test_drained_pause(10);
        test_back_to_back(100);

        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_digits.size() != 0) begin
            $display("%0t: %0d digits never arrived", $time, pending_digits.size());
        end

        $display("Converted %0d values into %0d digits: edge values, all lengths,",
                 values_sent, digits_seen);
        $display("bursty stalls on both sides, a drained pause and a full-rate stretch.");
        if (error_count == 0 && pending_digits.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
